// ===== rtl/acr_pkg.sv =====
// Package for the ARP cache and responder: payload structs, codes and constants.
// Used by arp_cache_responder.sv and its testbench; depends on nothing.
package acr_pkg;

    localparam int CACHE_ENTRIES_DEF = 16;

    localparam logic [10:0] MIN_FRAME   = 11'd42;
    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  HW_LEN      = 8'd6;
    localparam logic [7:0]  PROTO_LEN   = 8'd4;
    localparam logic [15:0] OP_REQUEST  = 16'd1;
    localparam logic [15:0] OP_REPLY    = 16'd2;

    typedef enum logic [1:0] {
        ACT_PACKET = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_IGNORE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SHORT     = 2'd1,
        STATUS_BAD_FMT   = 2'd2,
        STATUS_UNKNOWN_OP = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        action_t      action;
        logic [10:0]  frame_length;
        logic [15:0]  hardware_type;
        logic [15:0]  protocol_type;
        logic [7:0]   hw_addr_len;
        logic [7:0]   proto_addr_len;
        logic [15:0]  operation;
        logic [31:0]  sender_ip;
        logic [47:0]  sender_mac;
        logic [31:0]  target_ip;
        logic [31:0]  query_ip;
    } item_t;

    typedef struct packed {
        status_t      status;
        logic         send_reply;
        logic [31:0]  reply_ip;
        logic [47:0]  reply_mac;
        logic         hit;
        logic [47:0]  found_mac;
        logic         table_full;
        logic [4:0]   entries_used;
    } result_t;

    typedef struct packed {
        logic [31:0]  ip;
        logic [47:0]  mac;
    } entry_t;

endpackage

// ===== rtl/acr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module acr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/arp_cache_responder.sv =====
// Top level of the ARP cache and responder: sequencer, slot scan and result register.
// Depends on acr_pkg.sv and acr_ram.sv.
//
// One transaction is an ARP packet, a cache lookup, a cache clear or an ignored item, and
// gives one result transaction. A packet or lookup that reaches the cache scans the slots
// in use in order, and a match ends the scan early; every other transaction goes from
// decode straight to the result. A result that finishes while the one before it is still
// stalled in the output register holds the sequencer until that register is free. The
// entry RAM has one read port and one slot is compared per cycle. Slots fill in order, so
// the fill count alone marks which entries are live. A finished result waits in the output
// register while the next transaction is taken.
module arp_cache_responder
    import acr_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    localparam int AW    = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CACHE_ENTRIES);

    state_t            state_reg, state_next;
    logic [31:0]       local_ip_reg;
    item_t             item_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [AW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic              cmp_valid_reg, cmp_valid_next;
    status_t           status_reg, status_next;
    logic              hit_reg, hit_next;
    logic [47:0]       found_mac_reg, found_mac_next;
    logic              full_reg, full_next;
    logic              result_valid_reg, result_valid_next;
    result_t           result_reg, result_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    entry_t            ram_wentry;
    entry_t            ram_rentry;
    logic [31:0]       scan_key;
    logic              match;
    logic              scan_end;
    logic              load_result;
    status_t           decode_status;
    logic              send;
    logic [CNT_W+4:0]  count_ext;

    acr_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CACHE_ENTRIES)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (scan_idx_reg[AW-1:0]),
        .rdata (ram_rentry)
    );

    assign scan_key    = (item_reg.action == ACT_LOOKUP) ? item_reg.query_ip
                                                         : item_reg.sender_ip;
    assign match       = cmp_valid_reg && (ram_rentry.ip == scan_key);
    assign scan_end    = match || (scan_idx_reg == count_reg);
    assign load_result = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        if (item_reg.frame_length < MIN_FRAME)
        begin
            decode_status = STATUS_SHORT;
        end
        else if (item_reg.hardware_type != HW_ETHERNET || item_reg.protocol_type != PROTO_IPV4
                 || item_reg.hw_addr_len != HW_LEN || item_reg.proto_addr_len != PROTO_LEN)
        begin
            decode_status = STATUS_BAD_FMT;
        end
        else if (item_reg.operation == OP_REQUEST || item_reg.operation == OP_REPLY)
        begin
            decode_status = STATUS_OK;
        end
        else
        begin
            decode_status = STATUS_UNKNOWN_OP;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (item_reg.action == ACT_LOOKUP
                    || (item_reg.action == ACT_PACKET && decode_status == STATUS_OK))
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_result)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next        = count_reg;
        scan_idx_next     = scan_idx_reg;
        cmp_idx_next      = cmp_idx_reg;
        cmp_valid_next    = 1'b0;
        status_next       = status_reg;
        hit_next          = hit_reg;
        found_mac_next    = found_mac_reg;
        full_next         = full_reg;
        ram_we            = 1'b0;
        ram_waddr         = cmp_idx_reg;
        ram_wentry.ip     = item_reg.sender_ip;
        ram_wentry.mac    = item_reg.sender_mac;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        send              = 1'b0;
        count_ext         = {5'd0, count_reg};

        case (state_reg)
            ST_DECODE:
            begin
                status_next    = (item_reg.action == ACT_PACKET) ? decode_status : STATUS_OK;
                hit_next       = 1'b0;
                found_mac_next = '0;
                full_next      = 1'b0;
                scan_idx_next  = '0;
                if (item_reg.action == ACT_CLEAR)
                begin
                    count_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (!scan_end)
                begin
                    // issue the next slot read; its data is compared next cycle
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg[AW-1:0];
                    scan_idx_next  = scan_idx_reg + 1'b1;
                end
                else if (item_reg.action == ACT_LOOKUP)
                begin
                    hit_next       = match;
                    found_mac_next = match ? ram_rentry.mac : 48'd0;
                end
                else if (match)
                begin
                    // known sender: overwrite its MAC in place
                    ram_we = 1'b1;
                end
                else if (count_reg == FULL_COUNT)
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = count_reg[AW-1:0];
                    count_next = count_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                send = (item_reg.action == ACT_PACKET) && (status_reg == STATUS_OK)
                       && (item_reg.operation == OP_REQUEST)
                       && (item_reg.target_ip == local_ip_reg);
                if (load_result)
                begin
                    result_valid_next        = 1'b1;
                    result_next.status       = status_reg;
                    result_next.send_reply   = send;
                    result_next.reply_ip     = send ? item_reg.sender_ip : 32'd0;
                    result_next.reply_mac    = send ? item_reg.sender_mac : 48'd0;
                    result_next.hit          = hit_reg;
                    result_next.found_mac    = found_mac_reg;
                    result_next.table_full   = full_reg;
                    result_next.entries_used = count_ext[4:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            local_ip_reg     <= '0;
            count_reg        <= '0;
            cmp_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            cmp_valid_reg    <= cmp_valid_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write_en)
            begin
                local_ip_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && item_valid)
        begin
            item_reg <= item;
        end
        scan_idx_reg  <= scan_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        status_reg    <= status_next;
        hit_reg       <= hit_next;
        found_mac_reg <= found_mac_next;
        full_reg      <= full_next;
        result_reg    <= result_next;
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("slot count above cache size");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == ST_DECODE))
        else $error("accepted transaction not decoded");

    a_write_scope: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_SCAN && item_reg.action == ACT_PACKET))
        else $error("cache written outside a packet scan");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised without a finished transaction");

endmodule
